// ===== sv/qpt_pkg.sv =====
package qpt_pkg;

  localparam int unsigned CharW = 8;

  localparam logic [CharW-1:0] ChBackslash = 8'h5C;
  localparam logic [CharW-1:0] ChDquote    = 8'h22;
  localparam logic [CharW-1:0] ChSquote    = 8'h27;
  localparam logic [CharW-1:0] ChLetterN   = 8'h6E;
  localparam logic [CharW-1:0] ChNewline   = 8'h0A;
  localparam logic [CharW-1:0] ChSpace     = 8'h20;
  localparam logic [CharW-1:0] ChTab       = 8'h09;
  localparam logic [CharW-1:0] ChCr        = 8'h0D;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_ESCAPE   = 2'd1,
    ERR_TRAIL_BS = 2'd2,
    ERR_UNCLOSED = 2'd3
  } err_e;

  // space, tab, newline, vertical tab, form feed, carriage return
  function automatic logic is_blank(input logic [CharW-1:0] c);
    return (c == ChSpace) || (c inside {[ChTab:ChCr]});
  endfunction

endpackage

// ===== sv/qpt_in_if.sv =====
interface qpt_in_if;
  logic                      valid;
  logic                      ready;
  logic [qpt_pkg::CharW-1:0] char_in;
  logic                      line_last;

  modport source (output valid, output char_in, output line_last, input ready);
  modport sink   (input valid, input char_in, input line_last, output ready);
endinterface

// ===== sv/qpt_out_if.sv =====
interface qpt_out_if;
  logic                      valid;
  logic                      ready;
  logic                      char_valid;
  logic [qpt_pkg::CharW-1:0] char_out;
  logic                      token_end;
  logic                      line_done;
  logic [1:0]                error_code;

  modport source (output valid, output char_valid, output char_out, output token_end,
                  output line_done, output error_code, input ready);
  modport sink   (input valid, input char_valid, input char_out, input token_end,
                  input line_done, input error_code, output ready);
endinterface

// ===== sv/quoted_param_tokenizer.sv =====
// quoted parameter tokenizer
// in_i carries one byte of a parameter line per item, with line_last set on
// the final byte of the line. out_o carries at most one result item per input
// item: a parameter character (char_valid, char_out), a parameter end mark
// (token_end), a line end mark (line_done) or an error code (error_code).
// bytes that report nothing (whitespace between parameters, opening quotes,
// escaping backslashes, bytes after an error) give no result item at all.
// a result is registered and appears on out_o in the cycle after its byte is accepted.
// throughput: one byte per cycle unless out_o stalls, set by the single result
// register; the per-byte decode is a few compares against the scan state.
// stall: while a result waits on out_o with ready low, in_i.ready is low;
// in_i.ready comes back in the same cycle the waiting result is taken.
// reset: rst_ni clears the scan state (skipping whitespace, no open quote,
// no pending escape, no error) and empties the result register.
// every line end returns the scan state to its reset value as well.
module quoted_param_tokenizer (
  input  logic clk_i,
  input  logic rst_ni,
  qpt_in_if.sink    in_i,
  qpt_out_if.source out_o
);

  typedef enum logic [1:0] {
    MODE_SKIP   = 2'd0,
    MODE_PLAIN  = 2'd1,
    MODE_QUOTED = 2'd2
  } mode_e;

  // scan state
  mode_e mode_q, mode_d;
  logic  quote_dbl_q, quote_dbl_d;
  logic  esc_q, esc_d;
  logic  err_lat_q, err_lat_d;

  // result register
  logic                      out_valid_q, out_valid_d;
  logic                      char_valid_q, char_valid_d;
  logic [qpt_pkg::CharW-1:0] char_out_q, char_out_d;
  logic                      token_end_q, token_end_d;
  logic                      line_done_q, line_done_d;
  qpt_pkg::err_e             err_code_q, err_code_d;

  logic                      in_acc;
  logic                      emit;
  logic [qpt_pkg::CharW-1:0] c;
  logic                      last;
  logic                      closer_hit;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;
  assign c          = in_i.char_in;
  assign last       = in_i.line_last;
  assign closer_hit = quote_dbl_q ? (c == qpt_pkg::ChDquote) : (c == qpt_pkg::ChSquote);

  // per-byte decode
  always_comb begin
    mode_d       = mode_q;
    quote_dbl_d  = quote_dbl_q;
    esc_d        = 1'b0;
    err_lat_d    = err_lat_q;
    char_valid_d = 1'b0;
    char_out_d   = '0;
    token_end_d  = 1'b0;
    line_done_d  = last;
    err_code_d   = qpt_pkg::ERR_NONE;

    if (err_lat_q) begin
      // rest of the line is dropped, only the line end is reported
    end else if (esc_q) begin
      if (c == qpt_pkg::ChLetterN) begin
        char_valid_d = 1'b1;
        char_out_d   = qpt_pkg::ChNewline;
      end else if (c == qpt_pkg::ChSquote || c == qpt_pkg::ChDquote ||
                   c == qpt_pkg::ChBackslash) begin
        char_valid_d = 1'b1;
        char_out_d   = c;
      end else begin
        err_code_d = qpt_pkg::ERR_ESCAPE;
      end
      if (err_code_d == qpt_pkg::ERR_NONE && last) begin
        if (mode_q == MODE_QUOTED) err_code_d = qpt_pkg::ERR_UNCLOSED;
        else                       token_end_d = 1'b1;
      end
    end else begin
      case (mode_q)
        MODE_PLAIN: begin
          if (qpt_pkg::is_blank(c)) begin
            token_end_d = 1'b1;
            mode_d      = MODE_SKIP;
          end else if (c == qpt_pkg::ChBackslash) begin
            esc_d = 1'b1;
            if (last) err_code_d = qpt_pkg::ERR_TRAIL_BS;
          end else begin
            char_valid_d = 1'b1;
            char_out_d   = c;
            token_end_d  = last;
          end
        end
        MODE_QUOTED: begin
          if (closer_hit) begin
            token_end_d = 1'b1;
            mode_d      = MODE_SKIP;
            quote_dbl_d = 1'b0;
          end else if (c == qpt_pkg::ChBackslash) begin
            esc_d = 1'b1;
            if (last) err_code_d = qpt_pkg::ERR_TRAIL_BS;
          end else begin
            char_valid_d = 1'b1;
            char_out_d   = c;
            if (last) err_code_d = qpt_pkg::ERR_UNCLOSED;
          end
        end
        default: begin
          // skipping whitespace
          if (qpt_pkg::is_blank(c)) begin
            // separator, nothing to report
          end else if (c == qpt_pkg::ChDquote || c == qpt_pkg::ChSquote) begin
            mode_d      = MODE_QUOTED;
            quote_dbl_d = (c == qpt_pkg::ChDquote);
            if (last) err_code_d = qpt_pkg::ERR_UNCLOSED;
          end else if (c == qpt_pkg::ChBackslash) begin
            mode_d = MODE_PLAIN;
            esc_d  = 1'b1;
            if (last) err_code_d = qpt_pkg::ERR_TRAIL_BS;
          end else begin
            mode_d       = MODE_PLAIN;
            char_valid_d = 1'b1;
            char_out_d   = c;
            token_end_d  = last;
          end
        end
      endcase
    end

    // an error replaces whatever the byte would give
    if (err_code_d != qpt_pkg::ERR_NONE) begin
      char_valid_d = 1'b0;
      char_out_d   = '0;
      token_end_d  = 1'b0;
      if (!last) err_lat_d = 1'b1;
    end

    // line end returns everything to reset
    if (last) begin
      mode_d      = MODE_SKIP;
      quote_dbl_d = 1'b0;
      esc_d       = 1'b0;
      err_lat_d   = 1'b0;
    end

    emit = char_valid_d || token_end_d || line_done_d ||
           (err_code_d != qpt_pkg::ERR_NONE);

    // result register: load on a reporting byte, drop when taken
    if (in_acc) out_valid_d = emit;
    else if (out_o.ready) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_SKIP;
      quote_dbl_q <= 1'b0;
      esc_q       <= 1'b0;
      err_lat_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        mode_q      <= mode_d;
        quote_dbl_q <= quote_dbl_d;
        esc_q       <= esc_d;
        err_lat_q   <= err_lat_d;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      char_valid_q <= char_valid_d;
      char_out_q   <= char_out_d;
      token_end_q  <= token_end_d;
      line_done_q  <= line_done_d;
      err_code_q   <= err_code_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.char_valid = char_valid_q;
  assign out_o.char_out   = char_out_q;
  assign out_o.token_end  = token_end_q;
  assign out_o.line_done  = line_done_q;
  assign out_o.error_code = err_code_q;

endmodule

// ===== sv/qpt_checker.sv =====
module qpt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_last_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_char_valid_i,
  input logic       out_token_end_i,
  input logic       out_line_done_i,
  input logic [1:0] out_error_code_i
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // every line end shows up on the next cycle
  a_line_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> out_valid_i && out_line_done_i)
    else $error("line end not reported");

  // input only waits behind a stalled result
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without cause");

  // an error item carries no character and no parameter end
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_error_code_i != qpt_pkg::ERR_NONE) |->
      !out_char_valid_i && !out_token_end_i)
    else $error("error item with payload");

endmodule

bind quoted_param_tokenizer qpt_checker u_qpt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_last_i        (in_i.line_last),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_char_valid_i (out_o.char_valid),
  .out_token_end_i  (out_o.token_end),
  .out_line_done_i  (out_o.line_done),
  .out_error_code_i (out_o.error_code)
);

// ===== verif/tb_quoted_param_tokenizer.sv =====
`timescale 1ns / 100ps

module tb_quoted_param_tokenizer;

  localparam int CharW        = qpt_pkg::CharW;
  // cycles with no item moving on either side before the run is called hung
  localparam int StallLimit   = 1000;
  // drain time after the last expected result, well above the tokenizer's latency
  localparam int DrainCycles  = 8;
  localparam int PhaseBytes   = 534;
  localparam int ReportLimit  = 10;

  typedef enum logic [1:0] {
    SCAN_SKIP   = 2'd0,
    SCAN_PLAIN  = 2'd1,
    SCAN_QUOTED = 2'd2
  } scan_e;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
  } line_byte_t;

  typedef struct packed {
    logic             char_valid;
    logic [CharW-1:0] char_out;
    logic             token_end;
    logic             line_done;
    qpt_pkg::err_e    error_code;
  } token_res_t;

  logic clk_i;
  logic rst_ni;

  qpt_in_if  in_bus ();
  qpt_out_if out_bus ();

  quoted_param_tokenizer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // stimulus and expected results
  line_byte_t       pending_bytes[$];
  token_res_t       expected_results[$];
  logic [CharW-1:0] line_buf[$];

  int  bytes_queued   = 0;
  int  bytes_accepted = 0;
  int  fail_count     = 0;
  int  stall_cycles   = 0;
  int  send_idle_pct  = 0;
  int  recv_idle_pct  = 0;
  bit  in_fire        = 1'b0;
  bit  out_fire       = 1'b0;

  line_byte_t next_byte;
  token_res_t got_res;
  token_res_t want_res;

  // predictor state, mirrors the tokenizer's scan state
  scan_e pred_mode     = SCAN_SKIP;
  bit    pred_dquote   = 1'b0;
  bit    pred_escape   = 1'b0;
  bit    pred_err_held = 1'b0;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_ws(input logic [CharW-1:0] c);
    return (c == qpt_pkg::ChSpace) || (c >= qpt_pkg::ChTab && c <= qpt_pkg::ChCr);
  endfunction

  function automatic void clear_scan();
    pred_mode     = SCAN_SKIP;
    pred_dquote   = 1'b0;
    pred_escape   = 1'b0;
    pred_err_held = 1'b0;
  endfunction

  // returns 1 when the byte produces a result item, which lands in res
  function automatic bit tokenize_byte(input logic [CharW-1:0] c, input logic last,
                                       output token_res_t res);
    scan_e            mode;
    logic [CharW-1:0] closer;
    res = '{char_valid: 1'b0, char_out: '0, token_end: 1'b0, line_done: 1'b0,
            error_code: qpt_pkg::ERR_NONE};
    // after an error only the line end is reported
    if (pred_err_held) begin
      if (!last) return 1'b0;
      clear_scan();
      res.line_done = 1'b1;
      return 1'b1;
    end
    mode = pred_mode;
    if (pred_escape) begin
      pred_escape = 1'b0;
      if (c == qpt_pkg::ChLetterN) begin
        res.char_valid = 1'b1;
        res.char_out   = qpt_pkg::ChNewline;
      end else if (c == qpt_pkg::ChSquote || c == qpt_pkg::ChDquote ||
                   c == qpt_pkg::ChBackslash) begin
        res.char_valid = 1'b1;
        res.char_out   = c;
      end else begin
        res.error_code = qpt_pkg::ERR_ESCAPE;
      end
      if (res.error_code == qpt_pkg::ERR_NONE && last) begin
        if (mode == SCAN_QUOTED) res.error_code = qpt_pkg::ERR_UNCLOSED;
        else res.token_end = 1'b1;
      end
    end else begin
      case (mode)
        SCAN_PLAIN: begin
          if (is_ws(c)) begin
            res.token_end = 1'b1;
            mode = SCAN_SKIP;
          end else if (c == qpt_pkg::ChBackslash) begin
            pred_escape = 1'b1;
            if (last) res.error_code = qpt_pkg::ERR_TRAIL_BS;
          end else begin
            res.char_valid = 1'b1;
            res.char_out   = c;
            if (last) res.token_end = 1'b1;
          end
        end
        SCAN_QUOTED: begin
          closer = pred_dquote ? qpt_pkg::ChDquote : qpt_pkg::ChSquote;
          if (c == closer) begin
            // closing quote ends the parameter, even an empty one
            res.token_end = 1'b1;
            mode = SCAN_SKIP;
            pred_dquote = 1'b0;
          end else if (c == qpt_pkg::ChBackslash) begin
            pred_escape = 1'b1;
            if (last) res.error_code = qpt_pkg::ERR_TRAIL_BS;
          end else begin
            res.char_valid = 1'b1;
            res.char_out   = c;
            if (last) res.error_code = qpt_pkg::ERR_UNCLOSED;
          end
        end
        default: begin
          if (is_ws(c)) begin
            // whitespace between parameters reports nothing
          end else if (c == qpt_pkg::ChDquote || c == qpt_pkg::ChSquote) begin
            mode = SCAN_QUOTED;
            pred_dquote = (c == qpt_pkg::ChDquote);
            if (last) res.error_code = qpt_pkg::ERR_UNCLOSED;
          end else if (c == qpt_pkg::ChBackslash) begin
            mode = SCAN_PLAIN;
            pred_escape = 1'b1;
            if (last) res.error_code = qpt_pkg::ERR_TRAIL_BS;
          end else begin
            mode = SCAN_PLAIN;
            res.char_valid = 1'b1;
            res.char_out   = c;
            if (last) res.token_end = 1'b1;
          end
        end
      endcase
    end
    pred_mode = mode;
    // an error wipes the character and the end mark
    if (res.error_code != qpt_pkg::ERR_NONE) begin
      res.char_valid = 1'b0;
      res.char_out   = '0;
      res.token_end  = 1'b0;
      if (!last) pred_err_held = 1'b1;
    end
    if (last) clear_scan();
    res.line_done = last;
    return res.char_valid || res.token_end || (res.error_code != qpt_pkg::ERR_NONE) ||
           last;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic buf_add(input logic [CharW-1:0] c);
    line_buf.insert(line_buf.size(), c);
  endtask

  // moves the line buffer into the send queue, flagging its final byte
  task automatic flush_line();
    line_byte_t lb;
    foreach (line_buf[i]) begin
      lb.ch   = line_buf[i];
      lb.last = (i == line_buf.size() - 1);
      pending_bytes.insert(pending_bytes.size(), lb);
      bytes_queued++;
    end
    line_buf.delete();
  endtask

  task automatic queue_string(input string s);
    for (int i = 0; i < s.len(); i++) buf_add(s[i]);
    flush_line();
  endtask

  function automatic logic [CharW-1:0] blank_byte();
    if ($urandom_range(4) == 0) return qpt_pkg::ChSpace;
    return CharW'($urandom_range(qpt_pkg::ChTab, qpt_pkg::ChCr));
  endfunction

  // any byte that is an ordinary character everywhere
  function automatic logic [CharW-1:0] word_byte();
    logic [CharW-1:0] c;
    do begin
      c = CharW'($urandom_range(255));
    end while (is_ws(c) || c == qpt_pkg::ChBackslash || c == qpt_pkg::ChDquote ||
               c == qpt_pkg::ChSquote);
    return c;
  endfunction

  // any byte that is not a valid escape target
  function automatic logic [CharW-1:0] bad_escape_byte();
    logic [CharW-1:0] c;
    do begin
      c = CharW'($urandom_range(255));
    end while (c == qpt_pkg::ChLetterN || c == qpt_pkg::ChBackslash ||
               c == qpt_pkg::ChDquote || c == qpt_pkg::ChSquote);
    return c;
  endfunction

  // noise leans on the bytes the tokenizer treats specially
  function automatic logic [CharW-1:0] noise_byte();
    case ($urandom_range(5))
      0:       return qpt_pkg::ChBackslash;
      1:       return qpt_pkg::ChDquote;
      2:       return qpt_pkg::ChSquote;
      3:       return blank_byte();
      4:       return qpt_pkg::ChLetterN;
      default: return CharW'($urandom_range(255));
    endcase
  endfunction

  task automatic push_escape();
    buf_add(qpt_pkg::ChBackslash);
    case ($urandom_range(3))
      0:       buf_add(qpt_pkg::ChLetterN);
      1:       buf_add(qpt_pkg::ChBackslash);
      2:       buf_add(qpt_pkg::ChDquote);
      default: buf_add(qpt_pkg::ChSquote);
    endcase
  endtask

  task automatic push_blanks();
    repeat ($urandom_range(1, 2)) buf_add(blank_byte());
  endtask

  // body of a parameter: ordinary bytes with escapes, quotes where harmless
  task automatic push_body(input int len, input bit quoted, input logic [CharW-1:0] q);
    int pick;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(9);
      if (pick < 6) buf_add(word_byte());
      else if (pick < 8) push_escape();
      else if (quoted) buf_add((pick == 8) ? blank_byte() :
                               ((q == qpt_pkg::ChDquote) ? qpt_pkg::ChSquote :
                                                           qpt_pkg::ChDquote));
      // a quote at the start of an unquoted parameter would open a quote
      else if (i > 0) buf_add((pick == 8) ? qpt_pkg::ChDquote : qpt_pkg::ChSquote);
      else buf_add(word_byte());
    end
  endtask

  // one line: mostly well-formed parameters, some broken, some noise
  task automatic gen_random_line();
    int               n_par;
    int               kind;
    int               pos;
    logic [CharW-1:0] q;
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(1, 10)) buf_add(noise_byte());
    end else begin
      n_par = $urandom_range(1, 4);
      if ($urandom_range(3) == 0) push_blanks();
      for (int p = 0; p < n_par; p++) begin
        kind = $urandom_range(2);
        if (kind == 0) begin
          push_body($urandom_range(1, 6), 1'b0, qpt_pkg::ChSpace);
          if (p < n_par - 1) push_blanks();
        end else begin
          q = (kind == 1) ? qpt_pkg::ChSquote : qpt_pkg::ChDquote;
          buf_add(q);
          push_body($urandom_range(0, 6), 1'b1, q);
          buf_add(q);
          // text right after a closing quote starts a new parameter
          if (p < n_par - 1 && $urandom_range(3) != 0) push_blanks();
        end
      end
      if ($urandom_range(9) < 3) push_blanks();
      // break some of the lines on purpose
      case ($urandom_range(19))
        0, 1: begin
          pos = $urandom_range(line_buf.size());
          line_buf.insert(pos, bad_escape_byte());
          line_buf.insert(pos, qpt_pkg::ChBackslash);
        end
        2: buf_add(qpt_pkg::ChBackslash);
        3: begin
          buf_add(($urandom_range(1) == 0) ? qpt_pkg::ChSquote : qpt_pkg::ChDquote);
          push_body($urandom_range(0, 3), 1'b1, qpt_pkg::ChDquote);
        end
        default: ;
      endcase
    end
    flush_line();
  endtask

  function automatic string res_str(input token_res_t r);
    return $sformatf("cv=%0b ch=%02h te=%0b ld=%0b err=%0d", r.char_valid,
                     r.char_out, r.token_end, r.line_done, r.error_code);
  endfunction

  task automatic log_mismatch(input string what, input token_res_t want,
                              input token_res_t got);
    fail_count++;
    if (fail_count <= ReportLimit)
      $display("%0t %s: expected %s, got %s", $realtime, what, res_str(want),
               res_str(got));
  endtask

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // driver: new items and ready change on the falling edge
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (rst_ni) begin
      // a held item stays put until it is taken
      if (!in_bus.valid || in_fire) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_byte = pending_bytes.pop_front();
          in_bus.valid     <= 1'b1;
          in_bus.char_in   <= next_byte.ch;
          in_bus.line_last <= next_byte.last;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor, scoreboard and watchdog, all sampled on the rising edge
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // results first: a byte taken at this edge cannot answer at the same edge
      out_fire = out_bus.valid && out_bus.ready;
      if (out_fire) begin
        got_res.char_valid = out_bus.char_valid;
        got_res.char_out   = out_bus.char_out;
        got_res.token_end  = out_bus.token_end;
        got_res.line_done  = out_bus.line_done;
        got_res.error_code = qpt_pkg::err_e'(out_bus.error_code);
        if (expected_results.size() == 0) begin
          want_res = '0;
          log_mismatch("result with nothing expected", want_res, got_res);
        end else begin
          want_res = expected_results.pop_front();
          if (got_res.char_valid !== want_res.char_valid ||
              got_res.char_out   !== want_res.char_out   ||
              got_res.token_end  !== want_res.token_end  ||
              got_res.line_done  !== want_res.line_done  ||
              got_res.error_code !== want_res.error_code)
            log_mismatch("result mismatch", want_res, got_res);
        end
      end
      in_fire = in_bus.valid && in_bus.ready;
      if (in_fire) begin
        bytes_accepted++;
        if (tokenize_byte(in_bus.char_in, in_bus.line_last, want_res))
          expected_results.insert(expected_results.size(), want_res);
      end
      if (in_fire || out_fire) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence: reset, directed lines, three random phases, drain
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni           = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.char_in   = '0;
    in_bus.line_last = 1'b0;
    out_bus.ready    = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 30;
    recv_idle_pct = 66;

    // byte extremes as a plain parameter
    buf_add(8'h00);
    buf_add(8'hFF);
    flush_line();
    // other quote kind inside quotes, then text right after the closing quote
    queue_string("'a\"'x");
    // escaped newline inside double quotes, closing quote as the last byte
    queue_string("\"\\n\"");
    // invalid escape, the rest of the line is ignored
    queue_string("\\q b");
    // trailing backslash
    queue_string("a\\");
    // line ends inside quotes
    queue_string("'ab");
    // empty quoted parameter, then a blank as the last byte
    queue_string("\"\" ");
    // backslash before whitespace is an invalid escape too
    queue_string("\\ ");

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 30; recv_idle_pct = 66; end
        1: begin send_idle_pct = 66; recv_idle_pct = 30; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int n = bytes_queued; bytes_queued - n < PhaseBytes; ) gen_random_line();
      while (bytes_accepted != bytes_queued) @(posedge clk_i);
    end

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_results.size() != 0) fail_count++;

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/qpt_pkg.sv
sv/qpt_in_if.sv
sv/qpt_out_if.sv
sv/quoted_param_tokenizer.sv
sv/qpt_checker.sv
verif/tb_quoted_param_tokenizer.sv
